/* hdl/djs_pkg.sv */
// shared constants and types for the deadline job sequencer
package djs_pkg;
   localparam int MaxJobsDefault = 16;
   localparam int QueueDepth = 2;
   localparam int IdW = 8;
   localparam int DlW = 8;
   localparam int PrW = 16;
   localparam int SlotW = 4;
   localparam int TotW = 20;
   localparam logic [TotW-1:0] TotalMax = 20'hFFFFF;

   // one job passed from the front end to the back end
   typedef struct packed {
      logic [IdW-1:0] id;
      logic [DlW-1:0] deadline;
      logic [PrW-1:0] profit;
      logic           last;
   } job_type;
endpackage

/* hdl/djs_front.sv */
// front end: accepts jobs and queues them for the back end
module djs_front #(
   parameter int Depth = djs_pkg::QueueDepth
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  djs_pkg::job_type push_job,
   output logic            full,
   input  logic            pop,
   output logic            not_empty,
   output djs_pkg::job_type head_job
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   djs_pkg::job_type q_ff [Depth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(Depth));
   assign not_empty = (cnt_ff != '0);
   assign head_job  = q_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= push_job;
   end
endmodule

/* hdl/djs_back.sv */
// back end: ordered insert, slot assignment and result emission
module djs_back #(
   parameter int MaxJobs = djs_pkg::MaxJobsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  djs_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_valid,
   output logic [djs_pkg::SlotW-1:0] rsp_slot_index,
   output logic [djs_pkg::IdW-1:0]   rsp_sched_id,
   output logic [djs_pkg::PrW-1:0]   rsp_sched_profit,
   output logic [djs_pkg::TotW-1:0]  rsp_total_profit,
   output logic             rsp_is_total,
   output logic             rsp_overflowed,
   output logic             rsp_end_of_run
);
   localparam int IW = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
   localparam int NW = $clog2(MaxJobs + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEEK   = 3'd1;
   localparam logic [2:0] S_SHIFT  = 3'd2;
   localparam logic [2:0] S_PICK   = 3'd3;
   localparam logic [2:0] S_PSRCH  = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;
   localparam logic [2:0] S_TOTAL  = 3'd6;

   // job store, memories
   logic [djs_pkg::IdW-1:0] st_id  [MaxJobs];
   logic [djs_pkg::DlW-1:0] st_dl  [MaxJobs];
   logic [djs_pkg::PrW-1:0] st_pr  [MaxJobs];
   logic [IW-1:0]           sl_job [MaxJobs];
   logic [MaxJobs-1:0]      taken_ff, taken_in;

   logic [2:0]  state_ff, state_in;
   logic [NW-1:0] cnt_ff, cnt_in;      // job count
   logic [NW-1:0] pos_ff, pos_in;      // insert scan / shift / job index / slot index
   logic [NW-1:0] j_ff, j_in;          // shift index / slot search index (one above slot) / emit phase flag
   logic          drop_ff, drop_in;
   logic          last_ff, last_in;
   djs_pkg::job_type cur_ff, cur_in;
   logic [djs_pkg::TotW-1:0] tot_ff, tot_in;
   logic [djs_pkg::DlW-1:0]  dl_ff;
   logic [djs_pkg::IdW-1:0]  rid_ff;
   logic [djs_pkg::PrW-1:0]  rpr_ff;
   logic [NW-1:0] rd_addr;
   logic [IW-1:0] sj_rd_ff;
   logic [djs_pkg::TotW:0] sum;

   // store write controls
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [djs_pkg::IdW-1:0] wr_id;
   logic [djs_pkg::DlW-1:0] wr_dl;
   logic [djs_pkg::PrW-1:0] wr_pr;
   logic          sl_we;
   logic [IW-1:0] sl_addr;

   // registered outputs
   logic rv_ff, rv_in;
   logic [djs_pkg::SlotW-1:0] ro_slot_ff, ro_slot_in;
   logic [djs_pkg::IdW-1:0]   ro_id_ff, ro_id_in;
   logic [djs_pkg::PrW-1:0]   ro_pr_ff, ro_pr_in;
   logic [djs_pkg::TotW-1:0]  ro_tot_ff, ro_tot_in;
   logic ro_ist_ff, ro_ist_in, ro_ovf_ff, ro_ovf_in;

   logic          rd_phase_ff, rd_phase_in;
   logic [NW-1:0] lim;

   assign job_pop = (state_ff == S_IDLE) && job_valid;

   assign rsp_valid        = rv_ff;
   assign rsp_slot_index   = ro_slot_ff;
   assign rsp_sched_id     = ro_id_ff;
   assign rsp_sched_profit = ro_pr_ff;
   assign rsp_total_profit = ro_tot_ff;
   assign rsp_is_total     = ro_ist_ff;
   assign rsp_overflowed   = ro_ovf_ff;
   assign rsp_end_of_run   = ro_ist_ff;

   // registered store reads (one address per cycle)
   always_ff @(posedge clock) begin
      rid_ff   <= st_id[rd_addr[IW-1:0]];
      rpr_ff   <= st_pr[rd_addr[IW-1:0]];
      dl_ff    <= st_dl[rd_addr[IW-1:0]];
      sj_rd_ff <= sl_job[rd_addr[IW-1:0]];
   end

   // store writes
   always_ff @(posedge clock) begin
      if (wr_en) begin
         st_id[wr_addr] <= wr_id;
         st_dl[wr_addr] <= wr_dl;
         st_pr[wr_addr] <= wr_pr;
      end
      if (sl_we) sl_job[sl_addr] <= pos_ff[IW-1:0];
   end

   assign sum = {1'b0, tot_ff} + (djs_pkg::TotW+1)'(rpr_ff);
   assign lim = ((NW'(dl_ff) > cnt_ff) || (dl_ff > djs_pkg::DlW'(MaxJobs)))
                ? cnt_ff : NW'(dl_ff);

   // sequencer
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; pos_in = pos_ff; j_in = j_ff;
      drop_in = drop_ff; last_in = last_ff; cur_in = cur_ff; tot_in = tot_ff;
      taken_in = taken_ff; rd_phase_in = rd_phase_ff;
      rd_addr = pos_ff;
      wr_en = 1'b0; wr_addr = pos_ff[IW-1:0];
      wr_id = cur_ff.id; wr_dl = cur_ff.deadline; wr_pr = cur_ff.profit;
      sl_we = 1'b0; sl_addr = j_ff[IW-1:0] - 1'b1;
      rv_in = 1'b0; ro_slot_in = '0; ro_id_in = '0; ro_pr_in = '0; ro_tot_in = '0;
      ro_ist_in = 1'b0; ro_ovf_in = drop_ff;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               cur_in  = job;
               last_in = job.last;
               pos_in  = '0;
               rd_phase_in = 1'b0;
               if (cnt_ff >= NW'(MaxJobs)) begin
                  drop_in = 1'b1;
                  if (job.last) begin
                     pos_in = '0; rd_phase_in = 1'b0; state_in = S_PICK;
                  end
               end else begin
                  state_in = S_SEEK;
               end
            end
         end
         // scan for insert position: wait for each stored entry's read, then compare its profit
         S_SEEK: begin
            if (pos_ff == cnt_ff) begin
               j_in = cnt_ff; state_in = S_SHIFT;
            end else if (!rd_phase_ff) begin
               rd_phase_in = 1'b1;
            end else begin
               rd_phase_in = 1'b0;
               if (rpr_ff >= cur_ff.profit) pos_in = pos_ff + 1'b1;
               else begin j_in = cnt_ff; state_in = S_SHIFT; end
            end
         end
         // move entries up one place, then write the new job
         S_SHIFT: begin
            if (j_ff == pos_ff) begin
               wr_en = 1'b1; wr_addr = pos_ff[IW-1:0];
               cnt_in = cnt_ff + 1'b1; rd_phase_in = 1'b0;
               if (last_ff) begin pos_in = '0; state_in = S_PICK; end
               else state_in = S_IDLE;
            end else if (!rd_phase_ff) begin
               rd_addr = j_ff - 1'b1; rd_phase_in = 1'b1;
            end else begin
               wr_en = 1'b1; wr_addr = j_ff[IW-1:0];
               wr_id = rid_ff; wr_pr = rpr_ff; wr_dl = dl_ff;
               j_in = j_ff - 1'b1; rd_phase_in = 1'b0;
            end
         end
         // fetch deadline of job pos
         S_PICK: begin
            if (pos_ff == cnt_ff) begin
               pos_in = '0; tot_in = '0; rd_phase_in = 1'b0; j_in = '0;
               state_in = S_EMIT;
            end else if (!rd_phase_ff) begin
               rd_phase_in = 1'b1;
            end else begin
               rd_phase_in = 1'b0; j_in = lim; state_in = S_PSRCH;
            end
         end
         // latest free slot below the limit, one slot per cycle
         S_PSRCH: begin
            if (j_ff == '0) begin
               pos_in = pos_ff + 1'b1; state_in = S_PICK;
            end else if (!taken_ff[j_ff[IW-1:0] - 1'b1]) begin
               taken_in[j_ff[IW-1:0] - 1'b1] = 1'b1;
               sl_we = 1'b1;
               pos_in = pos_ff + 1'b1; state_in = S_PICK;
            end else j_in = j_ff - 1'b1;
         end
         // walk slots: read slot job, then its fields, then emit
         S_EMIT: begin
            if (pos_ff == cnt_ff) begin
               state_in = S_TOTAL;
            end else if (!taken_ff[pos_ff[IW-1:0]]) begin
               pos_in = pos_ff + 1'b1;
            end else if (!rd_phase_ff) begin
               rd_phase_in = 1'b1;
            end else if (j_ff != '1) begin
               rd_addr = NW'(sj_rd_ff); j_in = '1;
            end else begin
               rd_addr = NW'(sj_rd_ff);
               rv_in = 1'b1;
               ro_slot_in = djs_pkg::SlotW'(pos_ff);
               ro_id_in = rid_ff; ro_pr_in = rpr_ff;
               tot_in = sum[djs_pkg::TotW] ? djs_pkg::TotalMax : sum[djs_pkg::TotW-1:0];
               rd_phase_in = 1'b0; j_in = '0;
               pos_in = pos_ff + 1'b1;
            end
         end
         S_TOTAL: begin
            rv_in = 1'b1; ro_tot_in = tot_ff; ro_ist_in = 1'b1;
            taken_in = '0; cnt_in = '0; drop_in = 1'b0; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; drop_ff <= 1'b0; taken_ff <= '0;
         rv_ff <= 1'b0; rd_phase_ff <= 1'b0; j_ff <= '0; pos_ff <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; drop_ff <= drop_in;
         taken_ff <= taken_in; rv_ff <= rv_in; rd_phase_ff <= rd_phase_in;
         j_ff <= j_in; pos_ff <= pos_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_ff <= last_in; cur_ff <= cur_in; tot_ff <= tot_in;
      ro_slot_ff <= ro_slot_in; ro_id_ff <= ro_id_in; ro_pr_ff <= ro_pr_in;
      ro_tot_ff <= ro_tot_in; ro_ist_ff <= ro_ist_in; ro_ovf_ff <= ro_ovf_in;
   end
endmodule

/* hdl/deadline_job_sequencer.sv */
// top level of the deadline job sequencer
// Jobs enter on start while busy is low and are queued for the back end, which
// inserts each in profit order, scanning and moving stored entries. The job
// marked final starts scheduling: each job searches slots one per cycle, then
// one result per filled slot and a closing total follow. Results appear for one
// cycle on rsp_valid and cannot be held off; busy stays high from the final job
// until the closing result has been given.
module deadline_job_sequencer #(
   parameter int MaxJobs = djs_pkg::MaxJobsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_job_id,
   input  logic [7:0]  req_job_deadline,
   input  logic [15:0] req_job_profit,
   input  logic        req_final_job,
   output logic        rsp_valid,
   output logic [3:0]  rsp_slot_index,
   output logic [7:0]  rsp_sched_id,
   output logic [15:0] rsp_sched_profit,
   output logic [19:0] rsp_total_profit,
   output logic        rsp_is_total,
   output logic        rsp_overflowed,
   output logic        rsp_end_of_run
);
   djs_pkg::job_type in_job, head_job;
   logic full, not_empty, pop, push, hold_ff;

   assign in_job = '{id: req_job_id, deadline: req_job_deadline,
                     profit: req_job_profit, last: req_final_job};
   assign push = start && !busy;
   // block new jobs while the queue is full, and from a final job until its run is done
   assign busy = full || hold_ff;

   always_ff @(posedge clock) begin
      if (reset) hold_ff <= 1'b0;
      else if (push && req_final_job) hold_ff <= 1'b1;
      else if (rsp_valid && rsp_end_of_run) hold_ff <= 1'b0;
   end

   djs_front #(.Depth(djs_pkg::QueueDepth)) u_front (
      .clock, .reset, .push, .push_job(in_job), .full,
      .pop, .not_empty, .head_job
   );

   djs_back #(.MaxJobs(MaxJobs)) u_back (
      .clock, .reset, .job_valid(not_empty), .job(head_job), .job_pop(pop),
      .rsp_valid, .rsp_slot_index, .rsp_sched_id, .rsp_sched_profit,
      .rsp_total_profit, .rsp_is_total, .rsp_overflowed, .rsp_end_of_run
   );
endmodule

/* hdl/djs_checker.sv */
// port checker for the deadline job sequencer
module djs_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_is_total,
   input logic       rsp_end_of_run,
   input logic [19:0] rsp_total_profit
);
   a_end_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_total == rsp_end_of_run)) else $error("end flag mismatch");
   a_slot_zero_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_total) |-> (rsp_total_profit == '0))
      else $error("total on slot result");
   a_busy_after_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_run) |=> !rsp_valid) else $error("result after end");
   // results only come while a run holds off new jobs
   a_busy_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while not busy");
endmodule

bind deadline_job_sequencer djs_checker u_djs_checker (
   .clock, .reset, .busy, .rsp_valid, .rsp_is_total, .rsp_end_of_run,
   .rsp_total_profit
);
